// ----- rtl/core/uqst_pkg.sv -----
// Package for the URL query string tokenizer.
// Holds limits, phase and code enums, and the transaction payload structs.
// No dependencies.
package uqst_pkg;

  localparam int MaxFieldLen = 64;
  localparam int MaxPairs    = 32;

  localparam int LenW    = $clog2(MaxFieldLen + 1);
  localparam int PairW   = $clog2(MaxPairs + 1);
  localparam int CfgW    = 6;
  localparam int SlotW   = 5;
  localparam int OffW    = 6;
  localparam int CountW  = 6;

  localparam logic [7:0] ChQuery = 8'h3F;  // '?'
  localparam logic [7:0] ChEq    = 8'h3D;  // '='
  localparam logic [7:0] ChAmp   = 8'h26;  // '&'

  localparam logic [CfgW-1:0] MaxPairsRst = CfgW'(MaxPairs);

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhKey   = 2'd1,
    PhValue = 2'd2,
    PhStop  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    RoleIgnored = 2'd0,
    RoleKey     = 2'd1,
    RoleValue   = 2'd2,
    RoleDelim   = 2'd3
  } role_e;

  typedef enum logic [2:0] {
    ErrNone       = 3'd0,
    ErrNoMark     = 3'd1,
    ErrMarkAtEnd  = 3'd2,
    ErrEmptyKey   = 3'd3,
    ErrKeyLong    = 3'd4,
    ErrEmptyValue = 3'd5,
    ErrValueLong  = 3'd6,
    ErrNoEquals   = 3'd7
  } err_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        data_byte;
    role_e             role;
    logic [SlotW-1:0]  slot;
    logic [OffW-1:0]   offset;
    logic              pair_done;
    logic [CountW-1:0] param_count;
    err_e              error_code;
    logic              finished;
  } out_item_t;

endpackage

// ----- rtl/core/url_query_string_tokenizer.sv -----
// Each input transaction passes the input register, then the result register.
// Throughput: one byte per cycle; the path state updates as a byte leaves the input
// register, so consecutive bytes flow without bubbles under no backpressure.
// Reset (rst_ni low, async): pipeline empty, parser in the before-'?' phase, counters and
// sticky error cleared, max_pairs back to 32. The last byte of a path clears the parser too.
// Depends on uqst_pkg.
module url_query_string_tokenizer
  import uqst_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_data_o
);

  // Configuration register
  logic [CfgW-1:0] max_pairs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pairs_q <= MaxPairsRst;
    end else if (cfg_we_i) begin
      max_pairs_q <= cfg_wdata_i;
    end
  end

  // Input register stage
  logic     s1_valid_q;
  in_item_t s1_data_q;
  logic     out_load;   // result register can take a new transaction
  logic     s1_adv;     // stage 1 hands its byte to the parser this cycle

  assign out_load   = !out_valid_o || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_load;
  assign in_stall_o = s1_valid_q && !out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_data_q <= in_data_i;
    end
  end

  // Parser state
  phase_e           phase_q, phase_d;
  logic [LenW-1:0]  key_len_q, key_len_d;
  logic [LenW-1:0]  val_len_q, val_len_d;
  logic [PairW-1:0] pairs_q, pairs_d;
  err_e             err_q, err_d;

  // Effective pair limit: 0 acts as 1, anything above the build limit clamps
  logic [PairW-1:0] limit;

  always_comb begin
    if (max_pairs_q == '0) begin
      limit = PairW'(1);
    end else if (int'(max_pairs_q) > MaxPairs) begin
      limit = PairW'(MaxPairs);
    end else begin
      limit = PairW'(max_pairs_q);
    end
  end

  out_item_t res;

  // One byte through the parser. Outputs depend only on the current state and byte.
  always_comb begin
    phase_e           ph;
    logic [7:0]       b;
    logic             last;
    logic             complete;
    err_e             err;
    logic [PairW-1:0] pairs_new;

    b         = s1_data_q.in_byte;
    last      = s1_data_q.in_last;
    complete  = 1'b0;
    err       = ErrNone;
    pairs_new = pairs_q;

    phase_d   = phase_q;
    key_len_d = key_len_q;
    val_len_d = val_len_q;
    err_d     = err_q;

    res.data_byte = b;
    res.role      = RoleIgnored;
    res.slot      = '0;
    res.offset    = '0;
    res.pair_done = 1'b0;
    res.finished  = last;

    // a lowered limit may already be met mid-path
    ph = phase_q;
    if ((ph == PhKey || ph == PhValue) && pairs_q >= limit) begin
      ph = PhStop;
    end
    phase_d = ph;

    case (ph)
      PhIdle: begin
        if (b == ChQuery) begin
          if (last) begin
            err = ErrMarkAtEnd;
          end else begin
            phase_d   = PhKey;
            key_len_d = '0;
            res.role  = RoleDelim;
            res.slot  = SlotW'(pairs_q);
          end
        end else if (last) begin
          err = ErrNoMark;
        end
      end
      PhKey, PhValue: begin
        if (b == ChQuery) begin
          // restart the current pair
          if (last) begin
            err = ErrMarkAtEnd;
          end else begin
            phase_d   = PhKey;
            key_len_d = '0;
            res.role  = RoleDelim;
            res.slot  = SlotW'(pairs_q);
          end
        end else if (ph == PhKey) begin
          if (b == ChEq) begin
            if (key_len_q == '0) begin
              err = ErrEmptyKey;
            end else if (int'(key_len_q) >= MaxFieldLen) begin
              err = ErrKeyLong;
            end else if (last) begin
              err = ErrEmptyValue;
            end else begin
              phase_d   = PhValue;
              val_len_d = '0;
              res.role  = RoleDelim;
              res.slot  = SlotW'(pairs_q);
            end
          end else if (b == ChAmp || last) begin
            err = ErrNoEquals;
          end else begin
            res.role   = RoleKey;
            res.slot   = SlotW'(pairs_q);
            res.offset = OffW'(key_len_q);
            if (int'(key_len_q) < MaxFieldLen) begin
              key_len_d = LenW'(key_len_q + 1'b1);
            end
          end
        end else if (b == ChAmp) begin
          if (val_len_q == '0) begin
            err = ErrEmptyValue;
          end else if (int'(val_len_q) >= MaxFieldLen) begin
            err = ErrValueLong;
          end else begin
            res.role = RoleDelim;
            complete = 1'b1;
          end
        end else if (last) begin
          // final value byte closes the pair; it counts toward the length
          if (int'(val_len_q) >= MaxFieldLen - 1) begin
            err = ErrValueLong;
          end else begin
            res.role   = RoleValue;
            res.offset = OffW'(val_len_q);
            complete   = 1'b1;
          end
        end else begin
          // a later '=' lands here as a plain value byte
          res.role   = RoleValue;
          res.slot   = SlotW'(pairs_q);
          res.offset = OffW'(val_len_q);
          if (int'(val_len_q) < MaxFieldLen) begin
            val_len_d = LenW'(val_len_q + 1'b1);
          end
        end

        if (complete) begin
          res.slot      = SlotW'(pairs_q);
          pairs_new     = PairW'(pairs_q + 1'b1);
          res.pair_done = 1'b1;
          key_len_d     = '0;
          val_len_d     = '0;
          phase_d       = (pairs_new >= limit) ? PhStop : PhKey;
        end
      end
      default: begin
        // stopped: bytes pass through as ignored
      end
    endcase

    if (err != ErrNone) begin
      if (err_q == ErrNone) begin
        err_d = err;
      end
      phase_d       = PhStop;
      res.role      = RoleIgnored;
      res.slot      = '0;
      res.offset    = '0;
      res.pair_done = 1'b0;
    end

    pairs_d         = pairs_new;
    res.param_count = (int'(pairs_new) > 63) ? CountW'(63) : CountW'(pairs_new);
    res.error_code  = err_d;

    // end of path: back to a clean parser for the next one
    if (last) begin
      phase_d   = PhIdle;
      key_len_d = '0;
      val_len_d = '0;
      pairs_d   = '0;
      err_d     = ErrNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      key_len_q <= '0;
      val_len_q <= '0;
      pairs_q   <= '0;
      err_q     <= ErrNone;
    end else if (s1_adv) begin
      phase_q   <= phase_d;
      key_len_q <= key_len_d;
      val_len_q <= val_len_d;
      pairs_q   <= pairs_d;
      err_q     <= err_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_o <= res;
    end
  end

  // Assertions
  a_done_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.pair_done |->
      (out_data_o.role == RoleDelim || out_data_o.role == RoleValue))
    else $error("pair_done on a byte that is neither delimiter nor value");

  a_ignored_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.role == RoleIgnored |->
      (out_data_o.slot == '0 && out_data_o.offset == '0 && !out_data_o.pair_done))
    else $error("ignored byte carries slot, offset or pair_done");

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(out_data_o.param_count) <= MaxPairs)
    else $error("param_count beyond pair limit");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_o && out_stall_i)
    else $error("input stalled with room in the pipeline");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_data_q.in_last |=> phase_q == PhIdle && pairs_q == '0 && err_q == ErrNone)
    else $error("parser not cleared after last byte");

endmodule
